FILE: sv/ckam_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and divider step function for the chroma key alpha mask.
package ckam_pkg;

  // register stages from input to output
  localparam int unsigned PipeDepth = 10;

  localparam int unsigned HueSector = 3840;
  localparam int unsigned HueFull   = 23040;

  localparam logic [7:0] AlphaOpaque = 8'd255;
  localparam logic [7:0] AlphaClear  = 8'd0;

  localparam logic [14:0] KeyHueLowRst  = 15'd5760;
  localparam logic [14:0] KeyHueHighRst = 15'd10240;
  localparam logic [12:0] KeySatLowRst  = 13'd1228;
  localparam logic [12:0] KeySatHighRst = 13'd4096;
  localparam logic [12:0] KeyValLowRst  = 13'd819;
  localparam logic [12:0] KeyValHighRst = 13'd4096;
  localparam logic [14:0] SoftHueLowRst = 15'd4480;
  localparam logic [14:0] SoftHueHighRst = 15'd11520;

  typedef enum logic [3:0] {
    RegKeyHueLow   = 4'd0,
    RegKeyHueHigh  = 4'd1,
    RegKeySatLow   = 4'd2,
    RegKeySatHigh  = 4'd3,
    RegKeyValLow   = 4'd4,
    RegKeyValHigh  = 4'd5,
    RegSoftHueLow  = 4'd6,
    RegSoftHueHigh = 4'd7
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
  } pix_out_t;

  typedef struct packed {
    logic [3:0]  index;
    logic [15:0] value;
  } cfg_wr_t;

  typedef struct packed {
    logic [23:0] rem;
    logic [12:0] quo;
  } dstep_t;

  // Four restoring quotient bits, hi down to hi-3 (bits below zero skipped).
  // Caller keeps rem < den << (hi+1).
  function automatic dstep_t div_step4(logic [23:0] rem, logic [12:0] quo,
                                       logic [15:0] den, logic [3:0] hi);
    dstep_t     res;
    logic [3:0] bi;
    res.rem = rem;
    res.quo = quo;
    bi      = hi;
    for (int k = 0; k < 4; k++) begin
      if (hi >= 4'(k)) begin
        bi = hi - 4'(k);
        if ((res.rem >> bi) >= {8'd0, den}) begin
          res.rem     = res.rem - ({8'd0, den} << bi);
          res.quo[bi] = 1'b1;
        end
      end
    end
    return res;
  endfunction

endpackage

FILE: sv/ckam_stream_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying one word of a given payload type.
interface ckam_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/chroma_key_alpha_mask_unit.sv
`timescale 1ns / 1ps
// Chroma key alpha mask: RGB to fixed-point HSV, key window and soft hue band alpha.
//
// Usage:
//   pix_in_i  : sink of red/green/blue words, taken when valid and ready are high.
//   pix_out_o : source of the same color plus alpha_out, one word per input word,
//               in order.
//   cfg_i     : register writes (index 0..7, others ignored), always ready. Write
//               only while no pixel is in flight.
// Pipeline:
//   A word taken on pix_in_i passes through ten register stages (prep, four radix-16
//   steps of the saturation and hue dividers, hue wrap, window compare, two steps of
//   the alpha divider, output), each holding one word, and shows on pix_out_o from the
//   last. One word per cycle is sustained while the receiver holds ready high.
// Reset:
//   rst_ni low empties the pipeline and loads the default key window.
// Stall:
//   When the receiver holds ready low, words collect in empty stages; pix_in_i
//   ready falls only once all ten stages are full. Nothing is dropped or repeated.
module chroma_key_alpha_mask_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  ckam_stream_if.sink   pix_in_i,
  ckam_stream_if.source pix_out_o,
  ckam_stream_if.sink   cfg_i
);

  localparam int unsigned NSt    = ckam_pkg::PipeDepth;
  localparam int unsigned StHsv  = 5;
  localparam int unsigned StCmp  = 6;
  localparam int unsigned StOut  = 9;

  typedef struct packed {
    logic [19:0] rem_s;
    logic [12:0] quo_s;
    logic [7:0]  den_s;
    logic [19:0] rem_h;
    logic [12:0] quo_h;
    logic [7:0]  den_h;
    logic [14:0] hue_off;
    logic        hue_neg;
    logic        mx_zero;
    logic        d_zero;
    logic [12:0] val;
  } div_t;

  typedef struct packed {
    logic [14:0] hue;
    logic [12:0] sat;
    logic [12:0] val;
  } hsv_t;

  typedef struct packed {
    logic [22:0] rem;
    logic [7:0]  quo;
    logic [14:0] den;
    logic        use_div;
    logic        sat;
    logic        in_key;
  } adiv_t;

  // configuration
  logic [14:0] khl_q, khh_q, shl_q, shh_q;
  logic [12:0] ksl_q, ksh_q, kvl_q, kvh_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      khl_q <= ckam_pkg::KeyHueLowRst;
      khh_q <= ckam_pkg::KeyHueHighRst;
      ksl_q <= ckam_pkg::KeySatLowRst;
      ksh_q <= ckam_pkg::KeySatHighRst;
      kvl_q <= ckam_pkg::KeyValLowRst;
      kvh_q <= ckam_pkg::KeyValHighRst;
      shl_q <= ckam_pkg::SoftHueLowRst;
      shh_q <= ckam_pkg::SoftHueHighRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.index)
        ckam_pkg::RegKeyHueLow:   khl_q <= cfg_i.data.value[14:0];
        ckam_pkg::RegKeyHueHigh:  khh_q <= cfg_i.data.value[14:0];
        ckam_pkg::RegKeySatLow:   ksl_q <= cfg_i.data.value[12:0];
        ckam_pkg::RegKeySatHigh:  ksh_q <= cfg_i.data.value[12:0];
        ckam_pkg::RegKeyValLow:   kvl_q <= cfg_i.data.value[12:0];
        ckam_pkg::RegKeyValHigh:  kvh_q <= cfg_i.data.value[12:0];
        ckam_pkg::RegSoftHueLow:  shl_q <= cfg_i.data.value[14:0];
        ckam_pkg::RegSoftHueHigh: shh_q <= cfg_i.data.value[14:0];
        default: ;
      endcase
    end
  end

  // pipeline control: a stage loads when it is empty or its word moves on
  logic [NSt-1:0] v_q;
  logic [NSt-1:0] en;

  always_comb begin
    en[NSt-1] = ~v_q[NSt-1] | pix_out_o.ready;
    for (int k = NSt - 2; k >= 0; k--) begin
      en[k] = ~v_q[k] | en[k+1];
    end
  end

  assign pix_in_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= pix_in_i.valid;
      for (int k = 1; k < NSt; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // stage 0: max/min, value, divider operands
  logic [7:0]  r, g, b, mx, mn, dd, pa, pb, mag;
  logic [11:0] t16;
  logic [12:0] vsum;
  div_t        dv0_d;

  always_comb begin
    r  = pix_in_i.data.red_in;
    g  = pix_in_i.data.green_in;
    b  = pix_in_i.data.blue_in;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    dd = mx - mn;
    // mx*4096/255 = 16*mx + floor(16*mx/255)
    t16  = {mx, 4'd0};
    vsum = {1'b0, t16} + {9'd0, t16[11:8]} + 13'd1;
    dv0_d.val = {1'b0, t16} + {8'd0, vsum[12:8]};
    if (r == mx) begin
      dv0_d.hue_off = 15'd0;
      pa = g;
      pb = b;
    end else if (g == mx) begin
      dv0_d.hue_off = 15'(2 * ckam_pkg::HueSector);
      pa = b;
      pb = r;
    end else begin
      dv0_d.hue_off = 15'(4 * ckam_pkg::HueSector);
      pa = r;
      pb = g;
    end
    dv0_d.hue_neg = pa < pb;
    mag           = dv0_d.hue_neg ? (pb - pa) : (pa - pb);
    dv0_d.rem_s   = {dd, 12'd0};
    dv0_d.quo_s   = '0;
    dv0_d.den_s   = mx;
    dv0_d.rem_h   = 20'(mag) * 20'(ckam_pkg::HueSector);
    dv0_d.quo_h   = '0;
    dv0_d.den_h   = dd;
    dv0_d.mx_zero = mx == 8'd0;
    dv0_d.d_zero  = dd == 8'd0;
  end

  // stages 1..4: quotient bits 12..9, 8..5, 4..1, then 0 for saturation and hue
  div_t             dv_q [0:StHsv-1];
  div_t             dv_d [1:StHsv-1];
  ckam_pkg::dstep_t st_s, st_h;

  always_comb begin
    st_s = '0;
    st_h = '0;
    for (int k = 1; k < StHsv; k++) begin
      st_s = ckam_pkg::div_step4({4'd0, dv_q[k-1].rem_s}, dv_q[k-1].quo_s,
                                 {8'd0, dv_q[k-1].den_s}, 4'(16 - 4 * k));
      st_h = ckam_pkg::div_step4({4'd0, dv_q[k-1].rem_h}, dv_q[k-1].quo_h,
                                 {8'd0, dv_q[k-1].den_h}, 4'(16 - 4 * k));
      dv_d[k]       = dv_q[k-1];
      dv_d[k].rem_s = st_s.rem[19:0];
      dv_d[k].quo_s = st_s.quo;
      dv_d[k].rem_h = st_h.rem[19:0];
      dv_d[k].quo_h = st_h.quo;
    end
  end

  // stage 5: hue sector offset and wrap
  hsv_t        hsv_d, hsv_q;
  logic [15:0] hs;

  always_comb begin
    if (dv_q[StHsv-1].hue_neg) begin
      hs = {1'b0, dv_q[StHsv-1].hue_off} - {3'd0, dv_q[StHsv-1].quo_h};
    end else begin
      hs = {1'b0, dv_q[StHsv-1].hue_off} + {3'd0, dv_q[StHsv-1].quo_h};
    end
    if (hs[15]) hs = hs + 16'(ckam_pkg::HueFull);
    hsv_d.hue = dv_q[StHsv-1].d_zero ? 15'd0 : hs[14:0];
    hsv_d.sat = dv_q[StHsv-1].mx_zero ? 13'd0 : dv_q[StHsv-1].quo_s;
    hsv_d.val = dv_q[StHsv-1].val;
  end

  // stage 6: window compare, band width, ramp numerator
  adiv_t       ad0_d;
  logic        in_soft;
  logic [15:0] wdt;

  always_comb begin
    ad0_d.in_key = (hsv_q.hue > khl_q) && (hsv_q.hue < khh_q) &&
                   (hsv_q.sat > ksl_q) && (hsv_q.sat < ksh_q) &&
                   (hsv_q.val > kvl_q) && (hsv_q.val < kvh_q);
    in_soft = (hsv_q.hue > shl_q) && (hsv_q.hue < shh_q);
    if (hsv_q.hue <= khl_q) begin
      wdt = {1'b0, khl_q} - {1'b0, shl_q};
    end else begin
      wdt = {1'b0, shh_q} - {1'b0, khh_q};
    end
    ad0_d.rem     = {hsv_q.hue, 8'd0} - {8'd0, hsv_q.hue};
    ad0_d.quo     = '0;
    ad0_d.den     = wdt[14:0];
    ad0_d.use_div = in_soft && !wdt[15] && (wdt != 16'd0);
    ad0_d.sat     = ad0_d.rem >= {wdt[14:0], 8'd0};
  end

  // stages 7, 8: alpha quotient, bits 7..4 then 3..0
  adiv_t            ad_q [0:2];
  adiv_t            ad_d [1:2];
  ckam_pkg::dstep_t st_a;

  always_comb begin
    st_a = '0;
    for (int k = 1; k < 3; k++) begin
      st_a = ckam_pkg::div_step4({1'b0, ad_q[k-1].rem}, {5'd0, ad_q[k-1].quo},
                                 {1'b0, ad_q[k-1].den}, 4'(11 - 4 * k));
      ad_d[k]     = ad_q[k-1];
      ad_d[k].rem = st_a.rem[22:0];
      ad_d[k].quo = st_a.quo[7:0];
    end
  end

  // stage 9: output word
  logic [7:0] alpha_d, alpha_q;

  always_comb begin
    if (ad_q[2].in_key) begin
      alpha_d = ckam_pkg::AlphaClear;
    end else if (ad_q[2].use_div && !ad_q[2].sat) begin
      alpha_d = ad_q[2].quo;
    end else begin
      alpha_d = ckam_pkg::AlphaOpaque;
    end
  end

  // payload registers
  ckam_pkg::pix_in_t pix_q [0:NSt-1];

  always_ff @(posedge clk_i) begin
    if (en[0] && pix_in_i.valid) begin
      pix_q[0] <= pix_in_i.data;
      dv_q[0]  <= dv0_d;
    end
    for (int k = 1; k < NSt; k++) begin
      if (en[k] && v_q[k-1]) pix_q[k] <= pix_q[k-1];
    end
    for (int k = 1; k < StHsv; k++) begin
      if (en[k] && v_q[k-1]) dv_q[k] <= dv_d[k];
    end
    if (en[StHsv] && v_q[StHsv-1]) hsv_q <= hsv_d;
    if (en[StCmp] && v_q[StCmp-1]) ad_q[0] <= ad0_d;
    for (int k = 1; k < 3; k++) begin
      if (en[StCmp+k] && v_q[StCmp+k-1]) ad_q[k] <= ad_d[k];
    end
    if (en[StOut] && v_q[StOut-1]) alpha_q <= alpha_d;
  end

  assign pix_out_o.valid          = v_q[StOut];
  assign pix_out_o.data.red_out   = pix_q[StOut].red_in;
  assign pix_out_o.data.green_out = pix_q[StOut].green_in;
  assign pix_out_o.data.blue_out  = pix_q[StOut].blue_in;
  assign pix_out_o.data.alpha_out = alpha_q;

endmodule

FILE: sv/ckam_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the chroma key alpha mask, bound to the top level.
module ckam_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input ckam_pkg::pix_out_t out_data_i
);

  logic [4:0] cnt_q, cnt_d;

  always_comb begin
    cnt_d = cnt_q;
    if (in_valid_i && in_ready_i) cnt_d = cnt_d + 5'd1;
    if (out_valid_i && out_ready_i) cnt_d = cnt_d - 5'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // held output word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("output word changed while stalled");

  // every output word traces back to an accepted input word
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> cnt_q != 5'd0)
    else $error("output word with nothing in flight");

  // with the output stage empty there is room upstream
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled while output stage empty");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 5'(ckam_pkg::PipeDepth))
    else $error("more words in flight than pipeline stages");

endmodule

bind chroma_key_alpha_mask_unit ckam_checker u_ckam_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pix_in_i.valid),
  .in_ready_i  (pix_in_i.ready),
  .out_valid_i (pix_out_o.valid),
  .out_ready_i (pix_out_o.ready),
  .out_data_i  (pix_out_o.data)
);

FILE: tb/chroma_key_alpha_mask_checker.sv
`timescale 1ns / 1ps
// Watches the pixel and register channels, predicts each output pixel and compares.
module chroma_key_alpha_mask_checker
  import ckam_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     pix_in_valid_i,
  input  logic     pix_in_ready_i,
  input  pix_in_t  pix_in_data_i,
  input  logic     pix_out_valid_i,
  input  logic     pix_out_ready_i,
  input  pix_out_t pix_out_data_i,
  input  logic     cfg_valid_i,
  input  logic     cfg_ready_i,
  input  cfg_wr_t  cfg_data_i,
  output int       fails_o,
  output int       pending_o,
  output int       checked_o,
  output int       keyed_o,
  output int       ramped_o
);

  // Register copy, held as plain signed ints so width differences go negative.
  int win_hue_lo, win_hue_hi, win_sat_lo, win_sat_hi;
  int win_val_lo, win_val_hi, band_hue_lo, band_hue_hi;

  pix_out_t pixels_due[$];
  pix_out_t want, got;

  function automatic pix_out_t key_pixel(pix_in_t px);
    int r, g, b, mx, mn, d;
    int sector, hue, sat, val, span, ramp;
    pix_out_t res;
    r      = px.red_in;
    g      = px.green_in;
    b      = px.blue_in;
    sector = HueSector;
    mx     = (r > g) ? r : g;
    mx     = (b > mx) ? b : mx;
    mn     = (r < g) ? r : g;
    mn     = (b < mn) ? b : mn;
    d      = mx - mn;
    val    = mx * 4096 / 255;
    sat    = 0;
    hue    = 0;
    if (mx != 0) sat = d * 4096 / mx;
    if (d != 0) begin
      // signed quotients truncate toward zero
      if (r == mx) hue = sector * (g - b) / d;
      else if (g == mx) hue = 2 * sector + sector * (b - r) / d;
      else hue = 4 * sector + sector * (r - g) / d;
      if (hue < 0) hue = hue + int'(HueFull);
    end
    res.red_out   = px.red_in;
    res.green_out = px.green_in;
    res.blue_out  = px.blue_in;
    res.alpha_out = AlphaOpaque;
    if (hue > win_hue_lo && hue < win_hue_hi && sat > win_sat_lo && sat < win_sat_hi &&
        val > win_val_lo && val < win_val_hi) begin
      res.alpha_out = AlphaClear;
    end else if (hue > band_hue_lo && hue < band_hue_hi) begin
      span = (hue <= win_hue_lo) ? win_hue_lo - band_hue_lo : band_hue_hi - win_hue_hi;
      if (span > 0) begin
        ramp          = hue * 255 / span;
        res.alpha_out = (ramp > 255) ? AlphaOpaque : 8'(ramp);
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_hue_lo  = KeyHueLowRst;
      win_hue_hi  = KeyHueHighRst;
      win_sat_lo  = KeySatLowRst;
      win_sat_hi  = KeySatHighRst;
      win_val_lo  = KeyValLowRst;
      win_val_hi  = KeyValHighRst;
      band_hue_lo = SoftHueLowRst;
      band_hue_hi = SoftHueHighRst;
      pixels_due.delete();
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_data_i.index)
          RegKeyHueLow:   win_hue_lo  = cfg_data_i.value[14:0];
          RegKeyHueHigh:  win_hue_hi  = cfg_data_i.value[14:0];
          RegKeySatLow:   win_sat_lo  = cfg_data_i.value[12:0];
          RegKeySatHigh:  win_sat_hi  = cfg_data_i.value[12:0];
          RegKeyValLow:   win_val_lo  = cfg_data_i.value[12:0];
          RegKeyValHigh:  win_val_hi  = cfg_data_i.value[12:0];
          RegSoftHueLow:  band_hue_lo = cfg_data_i.value[14:0];
          RegSoftHueHigh: band_hue_hi = cfg_data_i.value[14:0];
          default: ;
        endcase
      end
      if (pix_in_valid_i && pix_in_ready_i) pixels_due.push_back(key_pixel(pix_in_data_i));
      if (pix_out_valid_i && pix_out_ready_i) begin
        got = pix_out_data_i;
        if (pixels_due.size() == 0) begin
          fails_o++;
          if (fails_o <= 10)
            $display("%0t: unexpected output word r=%0d g=%0d b=%0d a=%0d", $realtime,
                     got.red_out, got.green_out, got.blue_out, got.alpha_out);
        end else begin
          want = pixels_due.pop_front();
          checked_o++;
          if (want.alpha_out == AlphaClear) keyed_o++;
          else if (want.alpha_out != AlphaOpaque) ramped_o++;
          if (got.red_out !== want.red_out || got.green_out !== want.green_out ||
              got.blue_out !== want.blue_out || got.alpha_out !== want.alpha_out) begin
            fails_o++;
            if (fails_o <= 10)
              $display("%0t: pixel mismatch: expected r=%0d g=%0d b=%0d a=%0d, got r=%0d g=%0d b=%0d a=%0d",
                       $realtime, want.red_out, want.green_out, want.blue_out, want.alpha_out,
                       got.red_out, got.green_out, got.blue_out, got.alpha_out);
          end
        end
      end
      pending_o = pixels_due.size();
    end
  end

endmodule

FILE: tb/chroma_key_alpha_mask_unit_test.sv
`timescale 1ns / 1ps
// Stimulus, register programming and verdict for the chroma key alpha mask unit.
module chroma_key_alpha_mask_unit_test;
  import ckam_pkg::*;

  localparam logic [3:0]  UnusedRegFirst = 4'd8;
  localparam int          UnusedRegCount = 8;
  localparam logic [7:0]  Extremes [4] = '{8'd0, 8'd1, 8'd254, 8'd255};
  // black, white, greys, primaries, hue wrap, key window, band edges, value boundary
  localparam logic [23:0] Swatches [22] = '{
    24'h000000, 24'hFFFFFF, 24'h808080, 24'h010101, 24'hFF0000, 24'h00FF00,
    24'h0000FF, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'hFF000A, 24'h28C828,
    24'hB3FF00, 24'h00FFCC, 24'h64C800, 24'h00F0A0, 24'h1A331A, 24'h1A341A,
    24'h0A0B0C, 24'h01FF00, 24'hFF01FF, 24'hFEFFFF
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  bit   quiet  = 1'b0;
  int   settings_used = 1;
  int   fails, pending, checked, keyed, ramped;

  always #1 clk_i = ~clk_i;

  ckam_stream_if #(.T(pix_in_t))  pix_in ();
  ckam_stream_if #(.T(pix_out_t)) pix_out ();
  ckam_stream_if #(.T(cfg_wr_t))  cfg ();

  chroma_key_alpha_mask_unit i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pix_in_i  (pix_in),
    .pix_out_o (pix_out),
    .cfg_i     (cfg)
  );

  chroma_key_alpha_mask_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .pix_in_valid_i  (pix_in.valid),
    .pix_in_ready_i  (pix_in.ready),
    .pix_in_data_i   (pix_in.data),
    .pix_out_valid_i (pix_out.valid),
    .pix_out_ready_i (pix_out.ready),
    .pix_out_data_i  (pix_out.data),
    .cfg_valid_i     (cfg.valid),
    .cfg_ready_i     (cfg.ready),
    .cfg_data_i      (cfg.data),
    .fails_o         (fails),
    .pending_o       (pending),
    .checked_o       (checked),
    .keyed_o         (keyed),
    .ramped_o        (ramped)
  );

  task automatic send_pixel(input pix_in_t px);
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      pix_in.valid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    pix_in.valid = 1'b1;
    pix_in.data  = px;
    do @(posedge clk_i); while (!pix_in.ready);
  endtask

  task automatic send_random(input int count);
    pix_in_t px;
    int      base;
    logic [7:0] a, b;
    repeat (count) begin
      case ($urandom_range(0, 4))
        0: px = 24'($urandom);
        1: begin
          // green dominant, where the key window sits by default
          px.green_in = 8'($urandom_range(60, 255));
          px.red_in   = 8'($urandom_range(0, px.green_in));
          px.blue_in  = 8'($urandom_range(0, px.green_in));
        end
        2: begin
          base        = $urandom_range(3, 252);
          px.red_in   = 8'(base + $urandom_range(0, 6) - 3);
          px.green_in = 8'(base + $urandom_range(0, 6) - 3);
          px.blue_in  = 8'(base + $urandom_range(0, 6) - 3);
        end
        3: begin
          px.red_in   = Extremes[$urandom_range(0, 3)];
          px.green_in = Extremes[$urandom_range(0, 3)];
          px.blue_in  = Extremes[$urandom_range(0, 3)];
        end
        default: begin
          // two equal components exercise the max tie order
          a = 8'($urandom);
          b = 8'($urandom);
          case ($urandom_range(0, 2))
            0: px = {a, a, b};
            1: px = {a, b, a};
            default: px = {b, a, a};
          endcase
        end
      endcase
      send_pixel(px);
    end
  endtask

  task automatic write_reg(input logic [3:0] idx, input int val);
    @(negedge clk_i);
    cfg.valid = 1'b1;
    cfg.data  = '{index: idx, value: 16'(val)};
    do @(posedge clk_i); while (!cfg.ready);
    @(negedge clk_i);
    cfg.valid = 1'b0;
  endtask

  // Registers change only with the pipeline empty.
  task automatic load_window(input int hl, input int hh, input int sl, input int sh,
                             input int vl, input int vh, input int fl, input int fh);
    @(negedge clk_i);
    pix_in.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (PipeDepth) @(negedge clk_i);
    write_reg(RegKeyHueLow, hl);
    write_reg(RegKeyHueHigh, hh);
    write_reg(RegKeySatLow, sl);
    write_reg(RegKeySatHigh, sh);
    write_reg(RegKeyValLow, vl);
    write_reg(RegKeyValHigh, vh);
    write_reg(RegSoftHueLow, fl);
    write_reg(RegSoftHueHigh, fh);
    settings_used++;
  endtask

  task automatic load_random_window();
    int hl, hh, sl, sh, vl, vh, fl, fh;
    hl = $urandom_range(0, 16000);
    hh = $urandom_range(hl, HueFull);
    sl = $urandom_range(0, 3000);
    sh = $urandom_range(sl, 4096);
    vl = $urandom_range(0, 3000);
    vh = $urandom_range(vl, 4096);
    if ($urandom_range(0, 3) == 0) begin
      // band may sit inside the window: width zero or negative
      fl = $urandom_range(0, HueFull);
      fh = $urandom_range(0, HueFull);
    end else begin
      fl = $urandom_range(0, hl);
      fh = $urandom_range(hh, HueFull);
    end
    load_window(hl, hh, sl, sh, vl, vh, fl, fh);
  endtask

  initial begin : out_ready_gen
    int run;
    pix_out.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (quiet || $urandom_range(0, 2) != 0) begin
        pix_out.ready = 1'b1;
        run = $urandom_range(1, 30);
      end else begin
        pix_out.ready = 1'b0;
        run = $urandom_range(1, 10);
      end
      repeat (run - 1) @(negedge clk_i);
    end
  end

  initial begin : stimulus
    pix_in.valid = 1'b0;
    pix_in.data  = '0;
    cfg.valid    = 1'b0;
    cfg.data     = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (Swatches[k]) send_pixel(Swatches[k]);
    send_random(150);

    load_window(0, 0, 0, 0, 0, 0, 0, 0);
    send_random(100);

    // all ones get clipped to the register widths; unknown indexes must not land
    load_window('hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF);
    for (int k = 0; k < UnusedRegCount; k++) write_reg(UnusedRegFirst + 4'(k), $urandom);
    send_random(100);

    // wide soft band so the ramp below the window stays below saturation
    load_window(16000, 18000, 0, 4096, 0, 4096, 0, HueFull);
    send_random(150);

    // band inside the window: width negative above the window
    load_window(6000, 12000, 1000, 4000, 500, 4000, 6000, 9000);
    send_random(100);

    load_window(0, HueFull, 0, 4097, 0, 4097, 0, 0);
    send_random(100);

    for (int n = 0; n < 5; n++) begin
      load_random_window();
      send_random(100);
    end

    load_random_window();
    quiet = 1'b1;
    send_random(200);

    @(negedge clk_i);
    pix_in.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (PipeDepth + 2) @(negedge clk_i);

    $display("Checked %0d pixels over %0d key window settings", checked, settings_used);
    $display("alpha cleared on %0d, ramped on %0d, opaque on the rest; %0d failures",
             keyed, ramped, fails);
    if (fails == 0) begin
      $display("chroma_key_alpha_mask_unit_test OK");
    end else begin
      $display("chroma_key_alpha_mask_unit_test NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("chroma_key_alpha_mask_unit_test NOT OK");
    $finish;
  end

endmodule
